// File: rtl/core/itoa_pkg.sv
// shared types, constants and the digit character function for the integer to text unit
package itoa_pkg;

    // default width of the converted value
    localparam int VALUE_WIDTH_DEF = 64;

    // configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_SIZE = 8'd1;

    // register reset values
    localparam logic [5:0] RADIX_RST    = 6'd10;
    localparam logic [7:0] BUF_SIZE_RST = 8'd66;

    // character codes
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_UPPER  = 8'h41;
    localparam logic [7:0] CHAR_LOWER  = 8'h61;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // input word
    typedef struct packed {
        logic [63:0] value;
        logic        is_signed;
    } t_item;

    // result word
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
        logic       error;
    } t_res;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic rd_first;
        logic rd_next;
        logic out_err;
        logic out_minus;
        logic out_digit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic early_err;
        logic step_done;
        logic quot_zero;
        logic fits;
        logic neg;
        logic rd_last;
    } t_sts;

    // digit value to character: 0-9, A-Z, a-z, codes past the set wrap around
    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [5:0] dm;
        dm = (d >= 6'd62) ? (d - 6'd62) : d;
        if (dm < 6'd10) begin
            return CHAR_ZERO + {2'b00, dm};
        end else if (dm < 6'd36) begin
            return CHAR_UPPER + {2'b00, dm - 6'd10};
        end else begin
            return CHAR_LOWER + {2'b00, dm - 6'd36};
        end
    endfunction

endpackage

// File: rtl/core/itoa_dp.sv
// datapath: config registers, digit divider, digit memory and result register
module itoa_dp #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [itoa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [itoa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  itoa_pkg::t_item                 i_item,
    input  itoa_pkg::t_cmd                  i_cmd,
    output itoa_pkg::t_sts                  o_sts,
    output itoa_pkg::t_res                  o_result,
    output logic                            o_strobe
);
    import itoa_pkg::*;

    localparam int STEPS = (VALUE_WIDTH + 7) / 8;
    localparam int PW    = STEPS * 8;
    localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int ND_W  = $clog2(VALUE_WIDTH + 1);
    localparam int AW    = $clog2(VALUE_WIDTH);

    logic [5:0]             r_radix;
    logic [7:0]             r_size;
    logic [PW-1:0]          r_mag;
    logic [5:0]             r_rem;
    logic [SCW-1:0]         r_step;
    logic [ND_W-1:0]        r_nd;
    logic                   r_neg;
    logic [AW-1:0]          r_rd_idx;
    logic [5:0]             r_rd_data;
    logic [5:0]             r_mem [VALUE_WIDTH];
    logic                   r_strobe;
    t_res                   r_out;

    logic [VALUE_WIDTH-1:0] w_v;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_sgn_bit;
    logic                   w_min;
    logic                   w_neg;
    logic [5:0]             w_base;
    logic [5:0]             n_rem;
    logic [7:0]             n_q;
    logic [AW-1:0]          w_rd_addr;
    logic [8:0]             w_need;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RST;
            r_size  <= BUF_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIX:    r_radix <= i_cfg_data[5:0];
                REG_BUF_SIZE: r_size  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // saturated base
    always_comb begin
        if (r_radix < 6'd2) begin
            w_base = 6'd2;
        end else if (r_radix > 6'd62) begin
            w_base = 6'd62;
        end else begin
            w_base = r_radix;
        end
    end

    // sign handling and early buffer checks on the incoming word
    assign w_v       = i_item.value[VALUE_WIDTH-1:0];
    assign w_sgn_bit = w_v[VALUE_WIDTH-1];
    assign w_min     = w_sgn_bit && (w_v[VALUE_WIDTH-2:0] == '0);
    assign w_neg     = i_item.is_signed && w_sgn_bit;
    assign w_mag     = w_neg ? ((~w_v) + VALUE_WIDTH'(1)) : w_v;

    assign o_sts.early_err = i_item.is_signed
                           ? ((r_size < 8'd3) || (w_sgn_bit && (w_min || (r_size < 8'd4))))
                           : (r_size < 8'd2);

    // eight restoring division bits per cycle, remainder stays below the base
    always_comb begin
        logic [6:0] t;
        n_rem = r_rem;
        n_q   = '0;
        for (int k = 0; k < 8; k++) begin
            t = {n_rem, r_mag[PW-1-k]};
            if (t >= {1'b0, w_base}) begin
                n_rem      = 6'(t - {1'b0, w_base});
                n_q[7-k]   = 1'b1;
            end else begin
                n_rem      = t[5:0];
            end
        end
    end

    // division and digit count registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag  <= PW'(w_mag);
            r_neg  <= w_neg;
            r_nd   <= '0;
            r_step <= '0;
            r_rem  <= '0;
        end else if (i_cmd.step) begin
            r_mag  <= (r_mag << 8) | PW'(n_q);
            r_rem  <= n_rem;
            r_step <= r_step + SCW'(1);
        end else if (i_cmd.store) begin
            r_nd   <= r_nd + ND_W'(1);
            r_rem  <= '0;
            r_step <= '0;
        end
    end

    // digit memory, least significant digit at address zero
    assign w_rd_addr = i_cmd.rd_first ? AW'(r_nd - ND_W'(1)) : AW'(r_rd_idx - AW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_nd[AW-1:0]] <= r_rem;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // read index follows the address of the registered read data
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_first || i_cmd.rd_next) begin
            r_rd_idx <= w_rd_addr;
        end
    end

    // status back to the controller
    assign w_need = 9'(r_nd) + {8'd0, r_neg} + 9'd1;

    assign o_sts.step_done = (r_step == SCW'(STEPS - 1));
    assign o_sts.quot_zero = (r_mag == '0);
    assign o_sts.fits      = (w_need <= {1'b0, r_size});
    assign o_sts.neg       = r_neg;
    assign o_sts.rd_last   = (r_rd_idx == '0);

    // result register, one word per strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.out_err || i_cmd.out_minus || i_cmd.out_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_err) begin
            r_out <= '{char_code: CHAR_NUL, last: 1'b1, error: 1'b1};
        end else if (i_cmd.out_minus) begin
            r_out <= '{char_code: CHAR_MINUS, last: 1'b0, error: 1'b0};
        end else if (i_cmd.out_digit) begin
            r_out <= '{char_code: digit_char(r_rd_data), last: (r_rd_idx == '0),
                       error: 1'b0};
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_strobe;

endmodule

// File: rtl/core/itoa_ctrl.sv
// controller: sequences division, size check and character emission
module itoa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  itoa_pkg::t_sts i_sts,
    output itoa_pkg::t_cmd o_cmd,
    output logic           busy
);
    import itoa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_PREP  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_sts.early_err) begin
                        o_cmd.out_err = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.step_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_sts.quot_zero ? S_CHK : S_DIV;
            end
            S_CHK: begin
                if (i_sts.fits) begin
                    n_state = S_PREP;
                end else begin
                    o_cmd.out_err = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_PREP: begin
                o_cmd.rd_first  = 1'b1;
                o_cmd.out_minus = i_sts.neg;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.out_digit = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: rtl/core/integer_to_text_any_base_unit.sv
// top level of the integer to text converter for bases 2 to 62
//
// Usage: write radix (index 0) and buffer_size (index 1) through the
// config port while the unit is idle. Start a conversion by raising start
// while busy is low; the input word is taken at that edge. The text comes
// out one character per word on o_result, each marked by o_strobe for one
// cycle, most significant digit first, an optional minus sign ahead of it
// and last set on the final character. A failed conversion gives one word
// with error set. The receiver cannot stall: every word must be taken in
// the cycle it is shown.
// Timing: an error found from the buffer size or the sign alone shows in
// the cycle after start. Otherwise the divider forms each digit, eight
// quotient bits per cycle; then the size is checked, the top digit is
// read and the characters are issued back to back. busy stays high until
// the last word has been issued.
// Reset restores radix 10 and buffer size 66 and returns to idle.
module integer_to_text_any_base_unit #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [itoa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [itoa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            start,
    input  itoa_pkg::t_item                 i_item,
    output logic                            busy,
    output itoa_pkg::t_res                  o_result,
    output logic                            o_strobe
);
    import itoa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    itoa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    // divider, digit store and result register
    itoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_result   (o_result),
        .o_strobe   (o_strobe)
    );

endmodule
